>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked concurrent assertions with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> sv/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// shared widths, defaults, opcodes and the queued command type
// ----------------------------------------------------------------------------
package hst_pkg;

  // field widths of the transactions
  localparam int OPCODE_W = 2;
  localparam int PIECE_W  = 4;
  localparam int SQUARE_W = 6;
  localparam int BONUS_W  = 16;
  localparam int SCORE_W  = 16;

  // parameter defaults
  localparam int SCORE_LIMIT_DEF = 16384;
  localparam int PIECE_CODES_DEF = 16;
  localparam int SQUARES_DEF     = 64;

  // widest values the parameter ranges allow
  localparam int ADDR_MAX_W = PIECE_W + SQUARE_W;
  localparam int MAG_MAX_W  = 15;

  // ageing divides by two to the power of this
  localparam int AGE_SHIFT = 3;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_AGE    = 2'd1,
    OP_READ   = 2'd2
  } hst_op_e;

  // classified command handed from front to back
  typedef struct packed {
    hst_op_e                     op;
    logic                        in_range;
    logic [ADDR_MAX_W-1:0]       addr;
    logic signed [SCORE_W-1:0]   bonus;
    logic [MAG_MAX_W-1:0]        mag;
  } hst_cmd_t;

endpackage

>>> sv/hst_if.sv
// ----------------------------------------------------------------------------
// hst_if
// valid/ready channels for request and result transactions
// ----------------------------------------------------------------------------
interface hst_in_if;
  logic                                valid;
  logic                                ready;
  logic [hst_pkg::OPCODE_W-1:0]        opcode;
  logic [hst_pkg::PIECE_W-1:0]         piece_code;
  logic [hst_pkg::SQUARE_W-1:0]        dest_square;
  logic signed [hst_pkg::BONUS_W-1:0]  bonus;

  modport source (output valid, output opcode, output piece_code, output dest_square,
                  output bonus, input ready);
  modport sink   (input valid, input opcode, input piece_code, input dest_square,
                  input bonus, output ready);
endinterface

interface hst_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hst_pkg::SCORE_W-1:0]  score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

>>> sv/history_score_table.sv
// An in-range read passes through S_RD_WAIT, an update through S_MUL, S_RECIP, S_CORR,
// S_QFIX and S_WRITE; a new request waits until the last one ends. The back-end
// sequencer owns the single score ram and the three-stage reciprocal divide.
// An age transaction walks the whole ram, one entry per cycle.
// After reset a clearing sweep writes zeros to all PIECE_CODES*SQUARES entries
// (1024 by default); requests are not accepted until it ends.
// ----------------------------------------------------------------------------
// history_score_table
// signed history score table with gravity update, ageing and read
// ----------------------------------------------------------------------------
module history_score_table #(
  parameter int SCORE_LIMIT = hst_pkg::SCORE_LIMIT_DEF,
  parameter int PIECE_CODES = hst_pkg::PIECE_CODES_DEF,
  parameter int SQUARES     = hst_pkg::SQUARES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hst_in_if.sink      in_i,
  hst_out_if.source   out_o
);

  logic               init_done;
  logic               push_valid, push_ready;
  hst_pkg::hst_cmd_t  push_data;
  logic               pop_valid, pop_ready;
  hst_pkg::hst_cmd_t  pop_data;

  // request decode
  hst_front #(
    .SCORE_LIMIT (SCORE_LIMIT),
    .PIECE_CODES (PIECE_CODES),
    .SQUARES     (SQUARES)
  ) u_front (
    .in_i         (in_i),
    .init_done_i  (init_done),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // command queue
  hst_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // execution over the score ram
  hst_back #(
    .SCORE_LIMIT (SCORE_LIMIT),
    .PIECE_CODES (PIECE_CODES),
    .SQUARES     (SQUARES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .init_done_o (init_done),
    .out_o       (out_o)
  );

endmodule

>>> sv/hst_ram.sv
// ----------------------------------------------------------------------------
// hst_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module hst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hst_front.sv
// ----------------------------------------------------------------------------
// hst_front
// accepts request transactions, decodes, range-checks and clamps them
// ----------------------------------------------------------------------------
module hst_front #(
  parameter int SCORE_LIMIT = hst_pkg::SCORE_LIMIT_DEF,
  parameter int PIECE_CODES = hst_pkg::PIECE_CODES_DEF,
  parameter int SQUARES     = hst_pkg::SQUARES_DEF
) (
  hst_in_if.sink               in_i,
  input  logic                 init_done_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output hst_pkg::hst_cmd_t    push_data_o
);

  localparam int AMW = hst_pkg::ADDR_MAX_W;
  localparam int SW  = hst_pkg::SCORE_W;
  localparam logic signed [SW-1:0] LIM_POS = SW'(SCORE_LIMIT);
  localparam logic signed [SW-1:0] LIM_NEG = -SW'(SCORE_LIMIT);

  logic signed [SW-1:0] bonus_clamped;
  logic signed [SW-1:0] bonus_abs;

  // handshake, held off during the clearing sweep
  assign in_i.ready   = push_ready_i && init_done_i;
  assign push_valid_o = in_i.valid && init_done_i;

  // bonus clamp and magnitude
  always_comb begin
    if (in_i.bonus > LIM_POS) begin
      bonus_clamped = LIM_POS;
    end else if (in_i.bonus < LIM_NEG) begin
      bonus_clamped = LIM_NEG;
    end else begin
      bonus_clamped = in_i.bonus;
    end
    bonus_abs = bonus_clamped[SW-1] ? -bonus_clamped : bonus_clamped;
  end

  // command classification
  always_comb begin
    case (hst_pkg::hst_op_e'(in_i.opcode))
      hst_pkg::OP_UPDATE: push_data_o.op = hst_pkg::OP_UPDATE;
      hst_pkg::OP_AGE:    push_data_o.op = hst_pkg::OP_AGE;
      default:            push_data_o.op = hst_pkg::OP_READ;
    endcase
    push_data_o.in_range = (int'(in_i.piece_code) < PIECE_CODES) &&
                           (int'(in_i.dest_square) < SQUARES);
    push_data_o.addr     = AMW'(in_i.piece_code) * AMW'(SQUARES) + AMW'(in_i.dest_square);
    push_data_o.bonus    = bonus_clamped;
    push_data_o.mag      = bonus_abs[hst_pkg::MAG_MAX_W-1:0];
  end

endmodule

>>> sv/hst_fifo.sv
// ----------------------------------------------------------------------------
// hst_fifo
// short command queue decoupling front and back
// ----------------------------------------------------------------------------
module hst_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  hst_pkg::hst_cmd_t    push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output hst_pkg::hst_cmd_t    pop_data_o
);

  localparam int DEPTH = hst_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hst_pkg::hst_cmd_t  mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/hst_back.sv
// ----------------------------------------------------------------------------
// hst_back
// sequencer over the score ram: clearing sweep, read, gravity update, ageing
// ----------------------------------------------------------------------------
module hst_back #(
  parameter int SCORE_LIMIT = hst_pkg::SCORE_LIMIT_DEF,
  parameter int PIECE_CODES = hst_pkg::PIECE_CODES_DEF,
  parameter int SQUARES     = hst_pkg::SQUARES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  hst_pkg::hst_cmd_t    cmd_i,
  output logic                 init_done_o,
  hst_out_if.source            out_o
);

  localparam int SW      = hst_pkg::SCORE_W;
  localparam int XW      = SW + 2;
  localparam int DEPTH   = PIECE_CODES * SQUARES;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAG_W   = $clog2(SCORE_LIMIT + 1);
  localparam int PROD_W  = $clog2(SCORE_LIMIT * SCORE_LIMIT + 1);
  localparam int RECIP_W = PROD_W + 1;
  localparam int QW      = MAG_W;
  // floor(2^PROD_W / limit): quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << PROD_W) / SCORE_LIMIT);
  localparam logic [MAG_W-1:0]   LIM_M  = MAG_W'(SCORE_LIMIT);
  localparam logic [PROD_W-1:0]  LIM_P  = PROD_W'(SCORE_LIMIT);
  localparam logic signed [XW-1:0] LIM_XP = XW'(SCORE_LIMIT);
  localparam logic signed [XW-1:0] LIM_XN = -XW'(SCORE_LIMIT);
  localparam logic signed [SW-1:0] AGE_BIAS = SW'((1 << hst_pkg::AGE_SHIFT) - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_MUL,
    S_RECIP,
    S_CORR,
    S_QFIX,
    S_WRITE,
    S_AGE
  } state_e;

  state_e               state_q;
  logic [AW:0]          cnt_q;
  hst_pkg::hst_cmd_t    cmd_q;
  logic signed [SW-1:0] entry_q;
  logic [PROD_W-1:0]    prod_q;
  logic [QW-1:0]        q0_q;
  logic [PROD_W-1:0]    ql_q;
  logic [QW-1:0]        q_q;
  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] score_q;

  logic                 out_free, pop, out_set;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [SW-1:0]        ram_wdata, ram_rdata;
  logic signed [SW-1:0] rdata_s, rdata_abs, aged;
  logic [2*MAG_W-1:0]   mul_full;
  logic [PROD_W+RECIP_W-1:0] recip_full;
  logic [2*MAG_W-1:0]   ql_full;
  logic [PROD_W-1:0]    rem;
  logic signed [XW-1:0] ext_entry, ext_bonus, ext_q, sum;
  logic signed [SW-1:0] next_score;

  assign out_free    = !out_valid_q || out_o.ready;
  assign pop         = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign cmd_ready_o = pop;
  assign init_done_o = (state_q != S_CLEAR);
  assign out_o.valid = out_valid_q;
  assign out_o.score = score_q;

  // ageing: divide by eight, truncating toward zero
  assign rdata_s   = ram_rdata;
  assign aged      = rdata_s[SW-1] ? ((rdata_s + AGE_BIAS) >>> hst_pkg::AGE_SHIFT)
                                   : (rdata_s >>> hst_pkg::AGE_SHIFT);

  // gravity datapath, one multiply per stage
  assign rdata_abs  = rdata_s[SW-1] ? -rdata_s : rdata_s;
  assign mul_full   = cmd_q.mag[MAG_W-1:0] * rdata_abs[MAG_W-1:0];
  assign recip_full = prod_q * RECIP;
  assign ql_full    = q0_q * LIM_M;
  assign rem        = prod_q - ql_q;

  // new entry with saturation
  always_comb begin
    ext_entry = {{(XW - SW){entry_q[SW-1]}}, entry_q};
    ext_bonus = {{(XW - SW){cmd_q.bonus[SW-1]}}, cmd_q.bonus};
    ext_q     = entry_q[SW-1] ? -XW'(q_q) : XW'(q_q);
    sum       = ext_entry + ext_bonus - ext_q;
    if (sum > LIM_XP) begin
      next_score = SW'(LIM_XP);
    end else if (sum < LIM_XN) begin
      next_score = SW'(LIM_XN);
    end else begin
      next_score = sum[SW-1:0];
    end
  end

  // result register load and release
  always_comb begin
    case (state_q)
      S_IDLE:    out_set = pop && (cmd_i.op != hst_pkg::OP_AGE) && !cmd_i.in_range;
      S_RD_WAIT: out_set = 1'b1;
      S_WRITE:   out_set = 1'b1;
      S_AGE:     out_set = (cnt_q == (AW + 1)'(DEPTH));
      default:   out_set = 1'b0;
    endcase
    out_valid_d = out_set || (out_valid_q && !out_o.ready);
  end

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_q.addr[AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cmd_i.addr[AW-1:0];
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
      end
      S_IDLE: begin
        ram_re = pop && (cmd_i.op != hst_pkg::OP_AGE) && cmd_i.in_range;
      end
      S_AGE: begin
        ram_re    = (cnt_q != (AW + 1)'(DEPTH));
        ram_raddr = cnt_q[AW-1:0];
        ram_we    = (cnt_q != '0);
        ram_waddr = AW'(cnt_q - 1'b1);
        ram_wdata = aged;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = next_score;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (AW + 1)'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cmd_q <= cmd_i;
            cnt_q <= '0;
            if (cmd_i.op == hst_pkg::OP_AGE) begin
              state_q <= S_AGE;
            end else if (!cmd_i.in_range) begin
              score_q <= '0;
            end else if (cmd_i.op == hst_pkg::OP_UPDATE) begin
              state_q <= S_MUL;
            end else begin
              state_q <= S_RD_WAIT;
            end
          end
        end
        S_RD_WAIT: begin
          score_q <= rdata_s;
          state_q <= S_IDLE;
        end
        S_MUL: begin
          entry_q <= rdata_s;
          prod_q  <= mul_full[PROD_W-1:0];
          state_q <= S_RECIP;
        end
        S_RECIP: begin
          q0_q    <= recip_full[PROD_W +: QW];
          state_q <= S_CORR;
        end
        S_CORR: begin
          ql_q    <= ql_full[PROD_W-1:0];
          state_q <= S_QFIX;
        end
        S_QFIX: begin
          q_q     <= q0_q + QW'(rem >= LIM_P);
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          score_q <= next_score;
          state_q <= S_IDLE;
        end
        S_AGE: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (AW + 1)'(DEPTH)) begin
            score_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  hst_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> sv/hst_checker.sv
// ----------------------------------------------------------------------------
// hst_checker
// port-level checks on result transactions, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hst_checker #(
  parameter int SCORE_LIMIT = hst_pkg::SCORE_LIMIT_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [hst_pkg::SCORE_W-1:0] out_score_i
);

  localparam logic signed [hst_pkg::SCORE_W-1:0] LIM_POS = hst_pkg::SCORE_W'(SCORE_LIMIT);
  localparam logic signed [hst_pkg::SCORE_W-1:0] LIM_NEG = -hst_pkg::SCORE_W'(SCORE_LIMIT);

  logic       in_acc, out_acc;
  logic [2:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result valid dropped while stalled")
  `ASSERT_NEXT(a_score_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_score_i), "result changed while stalled")
  `ASSERT_IMPLIES(a_no_orphan, clk_i, rst_ni, out_valid_i, pending_q != 3'd0, "result without an outstanding request")
  `ASSERT_IMPLIES(a_score_range, clk_i, rst_ni, out_valid_i, (out_score_i <= LIM_POS) && (out_score_i >= LIM_NEG), "score beyond limit")

endmodule

bind history_score_table hst_checker #(
  .SCORE_LIMIT (SCORE_LIMIT)
) u_hst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_score_i (out_o.score)
);
